[hdl/char_lcd_nibble_writer_top_macros.svh]
// Assertion macros shared by the character LCD nibble writer RTL.
`ifndef CHAR_LCD_NIBBLE_WRITER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_TOP_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define CLNW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CLNW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/clnw_pkg.sv]
// Types and constants for the character LCD nibble writer.
`timescale 1ns / 1ps
`default_nettype none

package clnw_pkg;

   localparam logic       KIND_CHAR      = 1'b0;
   localparam logic       KIND_CMD       = 1'b1;

   localparam logic       RS_INSTR       = 1'b0;
   localparam logic       RS_DATA        = 1'b1;

   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_HOME       = 8'h02;
   localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
   localparam logic [6:0] ROW_OFFSET     = 7'h40;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;

   localparam logic [7:0]  SHORT_WAIT_RESET = 8'd40;
   localparam logic [11:0] LONG_WAIT_RESET  = 12'd1600;

   localparam logic       REG_SHORT_WAIT = 1'b0;
   localparam logic       REG_LONG_WAIT  = 1'b1;

   // One byte sent as two nibble transfers.
   typedef struct packed {
      logic        rs;
      logic [7:0]  data;
      logic [11:0] wait_us;
   } lcd_byte_type;

endpackage

`default_nettype wire

[hdl/char_lcd_nibble_writer_top.sv]
// Top level of the character LCD nibble writer.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  req_kind, req_payload
//   rsp       out        rsp_valid/rsp_stall  rsp_reg_select, rsp_nibble, rsp_wait_us, rsp_last
//   csr       in         APB psel/penable     paddr, pwdata, prdata
//
// A transaction on req yields two nibble transfers (command or newline) or four
// (ordinary character), one per cycle while rsp is not stalled. The one-entry
// transfer plan register holds one transaction at a time: the next transaction
// is taken in the cycle the last nibble of the current plan moves to rsp.
// Reset is synchronous; the cursor returns to row 0, column 0.
// A stall on rsp holds the output register and then back-pressures req.
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_nibble_writer_top_macros.svh"

module char_lcd_nibble_writer_top
   import clnw_pkg::*;
#(
   parameter int COLUMNS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_payload,

   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_reg_select,
   output      logic [3:0]  rsp_nibble,
   output      logic [11:0] rsp_wait_us,
   output      logic        rsp_last,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);

   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);

   logic [7:0]       short_wait_ff;
   logic [11:0]      long_wait_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic             row_ff, row_in;

   logic             plan_valid_ff, plan_valid_in;
   logic             plan_two_ff, plan_two_in;
   logic [1:0]       idx_ff, idx_in;
   lcd_byte_type     byte_a_ff, byte_a_in;
   lcd_byte_type     byte_b_ff, byte_b_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_rs_ff, rsp_rs_in;
   logic [3:0]       rsp_nibble_ff, rsp_nibble_in;
   logic [11:0]      rsp_wait_ff, rsp_wait_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             cfg_write;
   logic             req_accept;
   logic             out_load;
   logic             plan_at_last;
   logic             plan_done;
   logic             is_newline;
   logic             wrap;
   logic [COL_W-1:0] col_step;
   logic [6:0]       addr;
   logic [11:0]      short_wait_ext;
   logic [11:0]      cmd_wait;
   lcd_byte_type     addr_byte;
   lcd_byte_type     cur_byte;

   // Configuration port.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_wait_ff <= SHORT_WAIT_RESET;
         long_wait_ff  <= LONG_WAIT_RESET;
      end else if (cfg_write) begin
         if (paddr[2] == REG_SHORT_WAIT) begin
            short_wait_ff <= pwdata[7:0];
         end else begin
            long_wait_ff <= pwdata[11:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_SHORT_WAIT) begin
         prdata = {24'd0, short_wait_ff};
      end else begin
         prdata = {20'd0, long_wait_ff};
      end
   end

   // Handshake control.
   assign out_load     = plan_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign plan_at_last = (idx_ff == (plan_two_ff ? 2'd3 : 2'd1));
   assign plan_done    = out_load && plan_at_last;
   assign req_stall    = plan_valid_ff && !plan_done;
   assign req_accept   = req_valid && !req_stall;

   // Transfer plan for the incoming transaction.
   always_comb begin
      is_newline     = (req_payload == CHAR_NEWLINE);
      wrap           = (col_ff == COL_MAX) || is_newline;
      col_step       = col_ff + COL_W'(1);
      short_wait_ext = {4'd0, short_wait_ff};
      if (req_payload == CMD_CLEAR || req_payload == CMD_HOME) begin
         cmd_wait = long_wait_ff;
      end else begin
         cmd_wait = short_wait_ext;
      end

      col_in = col_ff;
      row_in = row_ff;
      if (req_accept && req_kind == KIND_CHAR) begin
         if (wrap) begin
            col_in = '0;
            row_in = !row_ff;
         end else begin
            col_in = col_step;
         end
      end

      addr              = (row_in ? ROW_OFFSET : 7'd0) + {{(7 - COL_W){1'b0}}, col_in};
      addr_byte.rs      = RS_INSTR;
      addr_byte.data    = CMD_SET_ADDR | {1'b0, addr};
      addr_byte.wait_us = short_wait_ext;

      byte_b_in = addr_byte;
      if (req_kind == KIND_CMD) begin
         plan_two_in       = 1'b0;
         byte_a_in.rs      = RS_INSTR;
         byte_a_in.data    = req_payload;
         byte_a_in.wait_us = cmd_wait;
      end else if (is_newline) begin
         plan_two_in = 1'b0;
         byte_a_in   = addr_byte;
      end else begin
         plan_two_in       = 1'b1;
         byte_a_in.rs      = RS_DATA;
         byte_a_in.data    = req_payload;
         byte_a_in.wait_us = short_wait_ext;
      end

      plan_valid_in = plan_valid_ff;
      idx_in        = idx_ff;
      if (req_accept) begin
         plan_valid_in = 1'b1;
         idx_in        = 2'd0;
      end else if (out_load) begin
         if (plan_at_last) begin
            plan_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
         col_ff        <= '0;
         row_ff        <= 1'b0;
      end else begin
         plan_valid_ff <= plan_valid_in;
         idx_ff        <= idx_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         plan_two_ff <= plan_two_in;
         byte_a_ff   <= byte_a_in;
         byte_b_ff   <= byte_b_in;
      end
   end

   // Output register.
   always_comb begin
      if (plan_two_ff && idx_ff[1]) begin
         cur_byte = byte_b_ff;
      end else begin
         cur_byte = byte_a_ff;
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_rs_in     = rsp_rs_ff;
      rsp_nibble_in = rsp_nibble_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_last_in   = rsp_last_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = plan_valid_ff;
         rsp_rs_in    = cur_byte.rs;
         rsp_last_in  = plan_at_last;
         if (idx_ff[0]) begin
            rsp_nibble_in = cur_byte.data[3:0];
            rsp_wait_in   = cur_byte.wait_us;
         end else begin
            rsp_nibble_in = cur_byte.data[7:4];
            rsp_wait_in   = 12'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rs_ff     <= rsp_rs_in;
      rsp_nibble_ff <= rsp_nibble_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_select = rsp_rs_ff;
   assign rsp_nibble     = rsp_nibble_ff;
   assign rsp_wait_us    = rsp_wait_ff;
   assign rsp_last       = rsp_last_ff;

   `CLNW_ASSERT(a_plan_not_overwritten, req_accept && plan_valid_ff |-> plan_done, "plan overwritten before its last transfer")
   `CLNW_ASSERT(a_column_in_range, col_ff <= COL_MAX, "cursor column out of range")
   `CLNW_ASSERT(a_high_nibble_no_wait, out_load && !idx_ff[0] |=> rsp_wait_us == 12'd0, "high nibble carries a wait")
   `CLNW_ASSERT_ALWAYS(a_reset_clears_output, reset |=> !rsp_valid, "output valid right after reset")

endmodule

`default_nettype wire

[sim/char_lcd_nibble_writer_top_tb.sv]
// Self-checking testbench for the character LCD nibble writer top level.
`timescale 1ns / 1ps

module char_lcd_nibble_writer_top_tb;
   import clnw_pkg::*;

   localparam int COLUMNS     = 16;
   localparam int STALL_LIMIT = 4000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic        rs;
      logic [3:0]  nibble;
      logic [11:0] wait_us;
      logic        last;
   } lcd_transfer_type;

   class lcd_transfer_board;
      lcd_transfer_type expected_transfers[$];
      logic [7:0]       short_wait;
      logic [11:0]      long_wait;
      int               column;
      logic             row;
      int               errors;

      function new();
         short_wait = SHORT_WAIT_RESET;
         long_wait  = LONG_WAIT_RESET;
         column     = 0;
         row        = 1'b0;
         errors     = 0;
      endfunction

      function void set_register(logic index, logic [31:0] value);
         if (index == REG_SHORT_WAIT) begin
            short_wait = value[7:0];
         end else begin
            long_wait = value[11:0];
         end
      endfunction

      function void push_byte(logic rs, logic [7:0] data, logic [11:0] wait_us, logic last);
         expected_transfers.push_back('{rs, data[7:4], 12'd0, 1'b0});
         expected_transfers.push_back('{rs, data[3:0], wait_us, last});
      endfunction

      function void note_request(logic kind, logic [7:0] payload);
         logic [11:0] wait_us;
         logic [6:0]  addr;
         if (kind == KIND_CMD) begin
            wait_us = (payload == CMD_CLEAR || payload == CMD_HOME) ?
                      long_wait : {4'd0, short_wait};
            push_byte(RS_INSTR, payload, wait_us, 1'b1);
         end else begin
            if (payload != CHAR_NEWLINE) begin
               push_byte(RS_DATA, payload, {4'd0, short_wait}, 1'b0);
            end
            column++;
            if (column >= COLUMNS || payload == CHAR_NEWLINE) begin
               column = 0;
               row    = ~row;
            end
            addr = (row ? ROW_OFFSET : 7'd0) + 7'(column);
            push_byte(RS_INSTR, CMD_SET_ADDR | {1'b0, addr}, {4'd0, short_wait}, 1'b1);
         end
      endfunction

      function void check_transfer(logic rs, logic [3:0] nibble, logic [11:0] wait_us,
                                   logic last);
         lcd_transfer_type want;
         lcd_transfer_type got;
         got = '{rs, nibble, wait_us, last};
         if (expected_transfers.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("Unexpected transfer: rs=%0d nibble=%h wait=%0d last=%0d",
                        rs, nibble, wait_us, last);
            end
         end else begin
            want = expected_transfers.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  $display("Mismatch: expected rs=%0d nibble=%h wait=%0d last=%0d,",
                           want.rs, want.nibble, want.wait_us, want.last,
                           " got rs=%0d nibble=%h wait=%0d last=%0d",
                           got.rs, got.nibble, got.wait_us, got.last);
               end
            end
         end
      endfunction

      function int pending();
         return expected_transfers.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [7:0]  req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_reg_select;
   logic [3:0]  rsp_nibble;
   logic [11:0] rsp_wait_us;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   lcd_transfer_board board = new();
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_cycles   = 0;
   int quiet_cycles  = 0;

   char_lcd_nibble_writer_top #(
      .COLUMNS(COLUMNS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_reg_select(rsp_reg_select),
      .rsp_nibble(rsp_nibble),
      .rsp_wait_us(rsp_wait_us),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #1 clock = ~clock;

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall = (int'($urandom_range(99)) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_transfer(rsp_reg_select, rsp_nibble, rsp_wait_us, rsp_last);
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (psel && penable && pready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_item(input logic kind, input logic [7:0] payload);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         @(negedge clock);
         req_valid   = 1'b0;
         req_kind    = 1'($urandom_range(1));
         req_payload = 8'($urandom_range(255));
      end
      @(negedge clock);
      req_valid   = 1'b1;
      req_kind    = kind;
      req_payload = payload;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(kind, payload);
   endtask

   task automatic send_random(input int count);
      logic       kind;
      logic [7:0] payload;
      int         pick;
      repeat (count) begin
         pick = int'($urandom_range(99));
         if (pick < 25) begin
            kind    = KIND_CMD;
            payload = 8'($urandom_range(255));
         end else if (pick < 32) begin
            kind    = KIND_CMD;
            payload = $urandom_range(1) ? CMD_CLEAR : CMD_HOME;
         end else if (pick < 44) begin
            kind    = KIND_CHAR;
            payload = CHAR_NEWLINE;
         end else begin
            kind    = KIND_CHAR;
            payload = 8'($urandom_range(255));
         end
         send_item(kind, payload);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [31:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {index, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.set_register(index, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input logic [7:0] short_w,
                            input logic [11:0] long_w, input int count, input int hold);
      csr_write(REG_SHORT_WAIT, {24'd0, short_w});
      csr_write(REG_LONG_WAIT, {20'd0, long_w});
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      hold_cycles   = hold;
      send_random(count);
      wait_drained();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_kind    = KIND_CHAR;
      req_payload = 8'd0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = 3'd0;
      pwdata      = 32'd0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(KIND_CMD, 8'h00);
      send_item(KIND_CMD, CMD_CLEAR);
      send_item(KIND_CMD, CMD_HOME);
      send_item(KIND_CMD, 8'h03);
      send_item(KIND_CMD, 8'hFF);
      send_item(KIND_CMD, CHAR_NEWLINE);
      send_item(KIND_CHAR, 8'hFF);
      send_item(KIND_CHAR, 8'h00);
      send_item(KIND_CHAR, CHAR_NEWLINE);
      for (int i = 0; i < COLUMNS; i++) begin
         send_item(KIND_CHAR, 8'h41 + 8'(i));
      end
      wait_drained();

      run_phase(0, 0, 8'd0, 12'd0, 25, 0);
      run_phase(52, 0, 8'hFF, 12'hFFF, 30, 0);
      run_phase(0, 52, 8'($urandom_range(255)), 12'($urandom_range(4095)), 30, 300);
      run_phase(32, 32, 8'($urandom_range(255)), 12'($urandom_range(4095)), 30, 0);
      run_phase(0, 0, 8'd1, 12'hFFF, 20, 0);

      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
